### design/clfsm_pkg.sv
// ----------------------------------------------------------------------------
// Charger link debounce package
// Shared types, state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package clfsm_pkg;

  localparam int CountW = 10;
  localparam int TickW  = 8;
  localparam int MvW    = 13;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FULL_MV   = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] CFG_FIN_HOLD  = 2'd2;

  localparam logic [MvW-1:0]   FULL_MV_RESET  = 13'd4100;
  localparam logic [TickW-1:0] DEBOUNCE_RESET = 8'd120;
  localparam logic [TickW-1:0] FIN_HOLD_RESET = 8'd30;

  // Link status codes.
  localparam logic [1:0] LS_OFF      = 2'd0;
  localparam logic [1:0] LS_RUNNING  = 2'd1;
  localparam logic [1:0] LS_LOST     = 2'd2;
  localparam logic [1:0] LS_COMPLETE = 2'd3;

  // Charge level codes.
  localparam logic [1:0] LVL_NONE      = 2'd0;
  localparam logic [1:0] LVL_WARMUP    = 2'd1;
  localparam logic [1:0] LVL_CONFIRMED = 2'd2;

  typedef enum logic [2:0] {
    ST_NOTCONN  = 3'd0,
    ST_WARMUP   = 3'd1,
    ST_ACTIVE   = 3'd2,
    ST_FINISHED = 3'd3,
    ST_LOST     = 3'd4
  } fsm_state_t;

  typedef struct packed {
    logic [MvW-1:0]   full_mv;
    logic [TickW-1:0] debounce;
    logic [TickW-1:0] fin_hold;
  } cfg_t;

  typedef struct packed {
    fsm_state_t        fsm;
    logic [CountW-1:0] count;
    logic              notify;
    logic [1:0]        level;
    logic [1:0]        status;
  } link_regs_t;

  typedef struct packed {
    logic [1:0] link_status;
    logic [1:0] charge_level;
    logic       charging_started;
    logic       charge_full;
    logic       probe_used;
  } result_t;

endpackage

`default_nettype wire

### design/clfsm_cfg.sv
// ----------------------------------------------------------------------------
// Charger link configuration registers
// Holds the full-voltage threshold and the two hold times.
// ----------------------------------------------------------------------------
`default_nettype none

module clfsm_cfg
  import clfsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [12:0] wr_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_mv  <= FULL_MV_RESET;
      cfg.debounce <= DEBOUNCE_RESET;
      cfg.fin_hold <= FIN_HOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_FULL_MV:  cfg.full_mv  <= wr_data;
        CFG_DEBOUNCE: cfg.debounce <= wr_data[TickW-1:0];
        CFG_FIN_HOLD: cfg.fin_hold <= wr_data[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/clfsm_step.sv
// ----------------------------------------------------------------------------
// Charger link step logic
// Next state of the link machine and the result of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module clfsm_step
  import clfsm_pkg::*;
(
  input  wire link_regs_t   cur,
  input  wire cfg_t         cfg,
  input  wire logic [7:0]   tick_seconds,
  input  wire logic         status_pin_high,
  input  wire logic         probe_pin_high,
  input  wire logic [12:0]  battery_mv,
  output link_regs_t        nxt,
  output result_t           res
);

  logic [CountW:0]   warm_sum;
  logic [CountW-1:0] warm_cnt;
  logic              warm_done;
  logic              cnt_ge;
  logic              mv_full;
  fsm_state_t        fsm_next;

  assign warm_sum  = {1'b0, cur.count} + {{(CountW+1-TickW){1'b0}}, tick_seconds};
  assign warm_cnt  = warm_sum[CountW] ? COUNT_MAX : warm_sum[CountW-1:0];
  assign warm_done = warm_cnt >= {{(CountW-TickW){1'b0}}, cfg.debounce};
  assign cnt_ge    = cur.count >= {{(CountW-TickW){1'b0}}, tick_seconds};
  assign mv_full   = battery_mv >= cfg.full_mv;

  // Next state.
  always_comb begin
    fsm_next = cur.fsm;
    case (cur.fsm)
      ST_NOTCONN: begin
        if (!status_pin_high) fsm_next = ST_WARMUP;
      end
      ST_WARMUP: begin
        if (status_pin_high) fsm_next = cnt_ge ? ST_LOST : ST_NOTCONN;
        else if (probe_pin_high) fsm_next = ST_FINISHED;
        else if (warm_done) fsm_next = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (status_pin_high) fsm_next = mv_full ? ST_FINISHED : ST_LOST;
        else if (probe_pin_high) fsm_next = ST_FINISHED;
      end
      ST_FINISHED: begin
        if (status_pin_high) fsm_next = cnt_ge ? ST_LOST : ST_NOTCONN;
        else fsm_next = probe_pin_high ? ST_FINISHED : ST_ACTIVE;
      end
      ST_LOST: begin
        if (status_pin_high) fsm_next = cnt_ge ? ST_LOST : ST_NOTCONN;
        else fsm_next = ST_ACTIVE;
      end
      default: ;
    endcase
  end

  // Counter, flags and result fields.
  always_comb begin
    nxt.fsm    = fsm_next;
    nxt.count  = cur.count;
    nxt.notify = cur.notify;
    nxt.level  = cur.level;
    nxt.status = cur.status;
    res.charging_started = 1'b0;
    res.charge_full      = 1'b0;
    res.probe_used       = 1'b0;
    if (status_pin_high) begin
      case (cur.fsm)
        ST_ACTIVE: begin
          if (mv_full) begin
            nxt.status = LS_COMPLETE;
            nxt.count  = {{(CountW-TickW){1'b0}}, cfg.fin_hold};
            nxt.notify = 1'b1;
          end else begin
            nxt.status = LS_LOST;
            nxt.count  = {{(CountW-TickW){1'b0}}, cfg.debounce};
          end
        end
        ST_WARMUP, ST_FINISHED, ST_LOST: begin
          if (cnt_ge) begin
            nxt.count  = cur.count - {{(CountW-TickW){1'b0}}, tick_seconds};
            nxt.status = LS_LOST;
          end else begin
            // The hold ran out: a pending completion is reported now.
            nxt.count       = '0;
            nxt.status      = LS_OFF;
            res.charge_full = cur.notify;
            nxt.notify      = 1'b0;
          end
        end
        default: ;
      endcase
    end else begin
      case (cur.fsm)
        ST_NOTCONN: begin
          nxt.level = LVL_WARMUP;
          nxt.count = '0;
        end
        ST_WARMUP, ST_FINISHED, ST_ACTIVE: begin
          if (cur.fsm == ST_WARMUP) begin
            nxt.count = warm_cnt;
            if (warm_done) begin
              nxt.level            = LVL_CONFIRMED;
              res.charging_started = 1'b1;
            end
          end
          nxt.status     = LS_RUNNING;
          res.probe_used = 1'b1;
          if (probe_pin_high) begin
            nxt.status = LS_COMPLETE;
            nxt.count  = {{(CountW-TickW){1'b0}}, cfg.fin_hold};
            nxt.notify = 1'b1;
          end else if (cur.fsm == ST_FINISHED) begin
            nxt.notify = 1'b0;
          end
        end
        default: ;
      endcase
    end
    res.link_status  = nxt.status;
    res.charge_level = nxt.level;
  end

endmodule

`default_nettype wire

### design/charger_link_debounce_fsm_core.sv
// Latency: a request's result is registered when it is accepted and is on the output in the next cycle.
// Throughput: one request per cycle; the link state is registered when a request is accepted.
// A result that waits holds off the next request, which is taken in the cycle
// the waiting result leaves.
// Reset: synchronous; the machine goes to not connected with a cleared counter,
// and the configuration registers take 4100 mV, 120 s and 30 s.
// ----------------------------------------------------------------------------
// Charger link debounce core
// Tracks the charger link per time tick and reports status and charge events.
// ----------------------------------------------------------------------------
`default_nettype none

module charger_link_debounce_fsm_core
  import clfsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  tick_seconds,
  input  wire logic        status_pin_high,
  input  wire logic        probe_pin_high,
  input  wire logic [12:0] battery_mv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       link_status,
  output logic [1:0]       charge_level,
  output logic             charging_started,
  output logic             charge_full,
  output logic             probe_used
);

  cfg_t       cfg;
  link_regs_t regs;
  link_regs_t regs_next;
  result_t    res_next;
  result_t    res;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  clfsm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  clfsm_step u_step (
    .cur             (regs),
    .cfg             (cfg),
    .tick_seconds    (tick_seconds),
    .status_pin_high (status_pin_high),
    .probe_pin_high  (probe_pin_high),
    .battery_mv      (battery_mv),
    .nxt             (regs_next),
    .res             (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fsm    <= ST_NOTCONN;
      regs.count  <= '0;
      regs.notify <= 1'b0;
      regs.level  <= LVL_NONE;
      regs.status <= LS_OFF;
    end else if (accept) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign link_status      = res.link_status;
  assign charge_level     = res.charge_level;
  assign charging_started = res.charging_started;
  assign charge_full      = res.charge_full;
  assign probe_used       = res.probe_used;

  a_full_means_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && charge_full) |-> (link_status == LS_OFF))
    else $error("charge_full reported while the link is not off");

  a_started_confirms: assert property (@(posedge clk) disable iff (rst)
    (out_valid && charging_started) |-> (charge_level == LVL_CONFIRMED))
    else $error("charging_started without a confirmed charge level");

  a_notconn_count: assert property (@(posedge clk) disable iff (rst)
    (regs.fsm == ST_NOTCONN) |-> (regs.count == '0))
    else $error("seconds counter not cleared in not connected");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

### tb/sv/charger_link_checker.sv
// ----------------------------------------------------------------------------
// Charger link checker
// Watches the configuration, tick and report channels of the charger link
// core, predicts each report from its own copy of the link state and compares
// the reports field by field in order.
// ----------------------------------------------------------------------------
module charger_link_checker
  import clfsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  tick_seconds,
  input  logic        status_pin_high,
  input  logic        probe_pin_high,
  input  logic [12:0] battery_mv,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  link_status,
  input  logic [1:0]  charge_level,
  input  logic        charging_started,
  input  logic        charge_full,
  input  logic        probe_used,
  output int          mismatch_count,
  output int          reports_pending
);

  logic [MvW-1:0]    full_mv_limit;
  logic [TickW-1:0]  debounce_secs;
  logic [TickW-1:0]  fin_hold_secs;

  fsm_state_t        link_fsm;
  logic [CountW-1:0] hold_count;
  logic              full_owed;
  logic [1:0]        level_now;
  logic [1:0]        status_now;

  result_t           expected_reports[$];

  initial begin
    mismatch_count  = 0;
    reports_pending = 0;
  end

  task automatic mark_charge_complete;
    link_fsm   = ST_FINISHED;
    status_now = LS_COMPLETE;
    hold_count = CountW'(fin_hold_secs);
    full_owed  = 1'b1;
  endtask

  // Moves the link state by one tick and returns the report it causes.
  task automatic advance_link(input logic [7:0] secs, input logic pin, input logic probe,
                              input logic [12:0] mv, output result_t report);
    logic [CountW:0] sum;
    logic            started;
    logic            full;
    logic            used;
    started = 1'b0;
    full    = 1'b0;
    used    = 1'b0;
    if (pin) begin
      case (link_fsm)
        ST_ACTIVE: begin
          status_now = LS_LOST;
          link_fsm   = ST_LOST;
          hold_count = CountW'(debounce_secs);
          if (mv >= full_mv_limit) mark_charge_complete();
        end
        ST_WARMUP, ST_FINISHED, ST_LOST: begin
          if (hold_count >= CountW'(secs)) begin
            hold_count = hold_count - CountW'(secs);
            status_now = LS_LOST;
            link_fsm   = ST_LOST;
          end else begin
            hold_count = '0;
            status_now = LS_OFF;
            if (full_owed) begin
              full      = 1'b1;
              full_owed = 1'b0;
            end
            link_fsm = ST_NOTCONN;
          end
        end
        default: ;
      endcase
    end else begin
      case (link_fsm)
        ST_NOTCONN: begin
          level_now  = LVL_WARMUP;
          hold_count = '0;
          link_fsm   = ST_WARMUP;
        end
        ST_LOST: link_fsm = ST_ACTIVE;
        ST_WARMUP, ST_FINISHED, ST_ACTIVE: begin
          if (link_fsm == ST_WARMUP) begin
            sum = {1'b0, hold_count} + (CountW+1)'(secs);
            hold_count = (sum > (CountW+1)'(COUNT_MAX)) ? COUNT_MAX : sum[CountW-1:0];
            if (hold_count >= CountW'(debounce_secs)) begin
              level_now = LVL_CONFIRMED;
              started   = 1'b1;
              link_fsm  = ST_ACTIVE;
            end
          end
          status_now = LS_RUNNING;
          used       = 1'b1;
          // A high probe sample ends the charge, even during warm-up.
          if (probe) begin
            mark_charge_complete();
          end else if (link_fsm == ST_FINISHED) begin
            link_fsm  = ST_ACTIVE;
            full_owed = 1'b0;
          end
        end
        default: ;
      endcase
    end
    report.link_status      = status_now;
    report.charge_level     = level_now;
    report.charging_started = started;
    report.charge_full      = full;
    report.probe_used       = used;
  endtask

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      full_mv_limit = FULL_MV_RESET;
      debounce_secs = DEBOUNCE_RESET;
      fin_hold_secs = FIN_HOLD_RESET;
      link_fsm      = ST_NOTCONN;
      hold_count    = '0;
      full_owed     = 1'b0;
      level_now     = LVL_NONE;
      status_now    = LS_OFF;
      expected_reports.delete();
    end else begin
      // A report leaves no earlier than the cycle after its request, so pop first.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: report expected none, got status %0d level %0d", $time,
                   link_status, charge_level);
        end else begin
          want = expected_reports.pop_front();
          check_field("link_status", want.link_status, link_status);
          check_field("charge_level", want.charge_level, charge_level);
          check_field("charging_started", 2'(want.charging_started), 2'(charging_started));
          check_field("charge_full", 2'(want.charge_full), 2'(charge_full));
          check_field("probe_used", 2'(want.probe_used), 2'(probe_used));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FULL_MV:  full_mv_limit = cfg_data;
          CFG_DEBOUNCE: debounce_secs = cfg_data[TickW-1:0];
          CFG_FIN_HOLD: fin_hold_secs = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_link(tick_seconds, status_pin_high, probe_pin_high, battery_mv, want);
        expected_reports.push_back(want);
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

### tb/sv/tb_charger_link_debounce_fsm_core.sv
// ----------------------------------------------------------------------------
// Charger link debounce core testbench
// Drives directed and random tick requests through several register settings
// with random gaps and report stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_charger_link_debounce_fsm_core;
  import clfsm_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  tick_seconds;
  logic        status_pin_high;
  logic        probe_pin_high;
  logic [12:0] battery_mv;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  link_status;
  logic [1:0]  charge_level;
  logic        charging_started;
  logic        charge_full;
  logic        probe_used;

  int          mismatch_count;
  int          reports_pending;
  logic [12:0] full_mv_now;
  bit          gaps_on;

  charger_link_debounce_fsm_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .tick_seconds(tick_seconds),
    .status_pin_high(status_pin_high), .probe_pin_high(probe_pin_high),
    .battery_mv(battery_mv),
    .out_valid(out_valid), .out_ready(out_ready), .link_status(link_status),
    .charge_level(charge_level), .charging_started(charging_started),
    .charge_full(charge_full), .probe_used(probe_used)
  );

  charger_link_checker link_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .tick_seconds(tick_seconds),
    .status_pin_high(status_pin_high), .probe_pin_high(probe_pin_high),
    .battery_mv(battery_mv),
    .out_valid(out_valid), .out_ready(out_ready), .link_status(link_status),
    .charge_level(charge_level), .charging_started(charging_started),
    .charge_full(charge_full), .probe_used(probe_used),
    .mismatch_count(mismatch_count), .reports_pending(reports_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("tb_charger_link_debounce_fsm_core: errors");
    $finish;
  end

  // Report side: ready runs with short stalls, now and then a long one.
  initial begin
    int run;
    out_ready = 1'b0;
    forever begin
      run = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) run = run * 10;
      @(negedge clk) out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clk) out_ready <= 1'b0;
      repeat (run - 1) @(negedge clk);
    end
  end

  // Returns at the rising edge that accepts the request; valid stays high.
  task automatic send_tick(input logic [7:0] secs, input logic pin, input logic probe,
                           input logic [12:0] mv);
    int gap;
    gap = 0;
    if (gaps_on)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    tick_seconds    <= secs;
    status_pin_high <= pin;
    probe_pin_high  <= probe;
    battery_mv      <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic [12:0] full_mv, input logic [12:0] debounce,
                            input logic [12:0] fin_hold, input bit poke_unused);
    wait_idle();
    if (poke_unused) write_reg(2'd3, 13'($urandom));
    write_reg(CFG_FULL_MV, full_mv);
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_FIN_HOLD, fin_hold);
    @(negedge clk) cfg_valid <= 1'b0;
    full_mv_now = full_mv;
  endtask

  initial begin
    int          phase;
    int          n;
    int          burst_left;
    logic        burst_pin;
    logic [7:0]  secs;
    logic        probe;
    logic [12:0] mv;

    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    tick_seconds    = '0;
    status_pin_high = 1'b0;
    probe_pin_high  = 1'b0;
    battery_mv      = '0;
    gaps_on         = 1'b1;
    full_mv_now     = FULL_MV_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: 4100 mV, 120 s debounce, 30 s hold.
    send_tick(8'd0, 1'b1, 1'b0, 13'd0);      // disconnected while not connected
    send_tick(8'd255, 1'b0, 1'b1, 13'd8191); // connect, probe not looked at
    send_tick(8'd119, 1'b0, 1'b0, 13'd0);
    send_tick(8'd1, 1'b0, 1'b0, 13'd0);      // warm-up completes
    send_tick(8'd255, 1'b0, 1'b0, 13'd0);
    send_tick(8'd0, 1'b1, 1'b0, 13'd4100);   // disconnect at full voltage
    send_tick(8'd30, 1'b1, 1'b0, 13'd0);
    send_tick(8'd1, 1'b1, 1'b0, 13'd0);      // hold runs out, charge full fires
    send_tick(8'd0, 1'b0, 1'b0, 13'd0);
    send_tick(8'd0, 1'b0, 1'b1, 13'd0);      // probe finishes during warm-up
    send_tick(8'd5, 1'b0, 1'b0, 13'd0);      // finished back to active
    send_tick(8'd0, 1'b1, 1'b0, 13'd4099);   // disconnect just below full
    send_tick(8'd200, 1'b0, 1'b0, 13'd0);    // reconnect from lost connection
    send_tick(8'd0, 1'b1, 1'b0, 13'd8191);
    send_tick(8'd0, 1'b0, 1'b0, 13'd0);
    send_tick(8'd0, 1'b1, 1'b0, 13'd0);
    send_tick(8'd255, 1'b1, 1'b0, 13'd0);

    set_limits(13'd0, 13'd0, 13'd0, 1'b1);
    send_tick(8'd0, 1'b0, 1'b0, 13'd0);
    send_tick(8'd0, 1'b0, 1'b0, 13'd0);      // zero debounce completes at once
    send_tick(8'd0, 1'b1, 1'b0, 13'd0);
    send_tick(8'd0, 1'b1, 1'b0, 13'd0);
    send_tick(8'd1, 1'b1, 1'b0, 13'd0);

    set_limits(13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b0);
    send_tick(8'd0, 1'b0, 1'b0, 13'd0);
    send_tick(8'd255, 1'b0, 1'b0, 13'd0);
    send_tick(8'd0, 1'b1, 1'b0, 13'd8191);

    burst_left = 0;
    burst_pin  = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limits(FULL_MV_RESET, 13'(DEBOUNCE_RESET), 13'(FIN_HOLD_RESET), 1'b0);
        1: set_limits(13'd0, 13'd0, 13'd0, 1'b0);
        2: set_limits(13'h1FFF, 13'h00FF, 13'h00FF, 1'b0);
        default: set_limits(13'($urandom), {5'($urandom), 8'($urandom_range(0, 60))},
                            {5'($urandom), 8'($urandom_range(0, 60))}, 1'b0);
      endcase
      gaps_on = (phase != 3);
      for (n = 0; n < 130; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(8'($urandom), 1'($urandom), 1'($urandom), 13'($urandom));
        end else begin
          // Connected and disconnected stretches walk the machine through a session.
          if (burst_left == 0) begin
            burst_pin  = ~burst_pin;
            burst_left = burst_pin ? $urandom_range(1, 8) : $urandom_range(1, 12);
          end
          burst_left--;
          secs  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
          probe = ($urandom_range(0, 7) == 0);
          case ($urandom_range(0, 3))
            0: mv = full_mv_now;
            1: mv = full_mv_now - 13'd1;
            2: mv = full_mv_now + 13'd1;
            default: mv = 13'($urandom);
          endcase
          send_tick(secs, burst_pin, probe, mv);
        end
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_charger_link_debounce_fsm_core: clean");
    end else begin
      $display("tb_charger_link_debounce_fsm_core: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/clfsm_pkg.sv
design/clfsm_cfg.sv
design/clfsm_step.sv
design/charger_link_debounce_fsm_core.sv
tb/sv/charger_link_checker.sv
tb/sv/tb_charger_link_debounce_fsm_core.sv
